// ===== design/dd_odo_pkg.sv =====
// ----------------------------------------------------------------------------
// dd_odo_pkg: shared types and constants for the odometry block
// control word of the microprogram, register indexes and field widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dd_odo_pkg;

    // default geometry
    localparam int TABLE_BITS_DEF = 12;
    localparam int POS_WIDTH_DEF  = 48;

    // field widths
    localparam int VEL_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int ANGLE_W = 32;
    localparam int QUAT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd2;

    // register reset values
    localparam logic [GAIN_W-1:0]  DISTANCE_GAIN_RST = 24'd83886;
    localparam logic [GAIN_W-1:0]  TURN_GAIN_RST     = 24'd49538;
    localparam logic [ANGLE_W-1:0] START_HEADING_RST = 32'h4000_0000;

    // a quarter turn as binary angle
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // angle looked up in the sine table
    typedef enum logic [1:0] {
        ANG_YAW_COS,
        ANG_YAW_SIN,
        ANG_HALF_SIN,
        ANG_HALF_COS
    } ang_sel_t;

    // register that takes the signed table value
    typedef enum logic [2:0] {
        TL_NONE,
        TL_COS,
        TL_SIN,
        TL_QZ,
        TL_QW
    } trig_dst_t;

    // multiplier operand a
    typedef enum logic [1:0] {
        MA_SUM,
        MA_DIFF,
        MA_PROD
    } mul_a_t;

    // multiplier operand b
    typedef enum logic [1:0] {
        MB_COS,
        MB_SIN,
        MB_DGAIN,
        MB_TGAIN
    } mul_b_t;

    // accumulator that takes the product
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_X,
        ACC_Y,
        ACC_YAW
    } acc_t;

    // sequencing of the step counter
    typedef enum logic {
        NX_SEQ,
        NX_END
    } next_t;

    typedef struct packed {
        logic      rom_en;
        ang_sel_t  ang_sel;
        trig_dst_t trig_dst;
        logic      mul_en;
        mul_a_t    mul_a;
        mul_b_t    mul_b;
        acc_t      acc;
        logic      publish;
        next_t     next;
    } ctrl_t;

    localparam ctrl_t CTRL_IDLE = '{
        rom_en:   1'b0,
        ang_sel:  ANG_YAW_SIN,
        trig_dst: TL_NONE,
        mul_en:   1'b0,
        mul_a:    MA_SUM,
        mul_b:    MB_COS,
        acc:      ACC_NONE,
        publish:  1'b0,
        next:     NX_SEQ
    };

endpackage

`default_nettype wire

// ===== design/dd_odo_sine_rom.sv =====
// ----------------------------------------------------------------------------
// dd_odo_sine_rom: quarter-wave sine table
// q1.15 sine over a quarter turn, built at elaboration, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dd_odo_sine_rom #(
    parameter int TABLE_BITS = dd_odo_pkg::TABLE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  rd_en,
    input  wire logic [TABLE_BITS-2:0] rd_addr,
    output logic      [15:0]           rd_data
);

    localparam int QW    = TABLE_BITS - 2;
    localparam int DEPTH = (1 << QW) + 1;

    typedef logic [15:0] rom_t [DEPTH];

    // taylor series in q30, nested from the high terms down
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int i = 0; i < DEPTH; i++) begin
            x  = (64'(i) * 64'd1686629713) >> QW;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            r[i] = s[15:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= SINE_ROM[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/dd_odo_seq.sv =====
// ----------------------------------------------------------------------------
// dd_odo_seq: microprogram sequencer
// step counter over a control-word table, ends on a free result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dd_odo_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              out_free,
    output logic                   busy,
    output dd_odo_pkg::ctrl_t      ctrl
);

    localparam int STEP_W = 4;

    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    dd_odo_pkg::ctrl_t  word;

    // one control word per step
    function automatic dd_odo_pkg::ctrl_t prog(input logic [STEP_W-1:0] s);
        dd_odo_pkg::ctrl_t w;
        w = dd_odo_pkg::CTRL_IDLE;
        case (s)
            4'd0: begin
                w.rom_en  = 1'b1;
                w.ang_sel = dd_odo_pkg::ANG_YAW_COS;
            end
            4'd1: begin
                w.rom_en   = 1'b1;
                w.ang_sel  = dd_odo_pkg::ANG_YAW_SIN;
                w.trig_dst = dd_odo_pkg::TL_COS;
            end
            4'd2: begin
                w.trig_dst = dd_odo_pkg::TL_SIN;
                w.mul_en   = 1'b1;
                w.mul_a    = dd_odo_pkg::MA_SUM;
                w.mul_b    = dd_odo_pkg::MB_COS;
            end
            4'd3: begin
                w.mul_en = 1'b1;
                w.mul_a  = dd_odo_pkg::MA_PROD;
                w.mul_b  = dd_odo_pkg::MB_DGAIN;
            end
            4'd4: begin
                w.acc    = dd_odo_pkg::ACC_X;
                w.mul_en = 1'b1;
                w.mul_a  = dd_odo_pkg::MA_SUM;
                w.mul_b  = dd_odo_pkg::MB_SIN;
            end
            4'd5: begin
                w.mul_en = 1'b1;
                w.mul_a  = dd_odo_pkg::MA_PROD;
                w.mul_b  = dd_odo_pkg::MB_DGAIN;
            end
            4'd6: begin
                w.acc    = dd_odo_pkg::ACC_Y;
                w.mul_en = 1'b1;
                w.mul_a  = dd_odo_pkg::MA_DIFF;
                w.mul_b  = dd_odo_pkg::MB_TGAIN;
            end
            4'd7: begin
                w.acc = dd_odo_pkg::ACC_YAW;
            end
            4'd8: begin
                w.rom_en  = 1'b1;
                w.ang_sel = dd_odo_pkg::ANG_HALF_SIN;
            end
            4'd9: begin
                w.rom_en   = 1'b1;
                w.ang_sel  = dd_odo_pkg::ANG_HALF_COS;
                w.trig_dst = dd_odo_pkg::TL_QZ;
            end
            4'd10: begin
                w.trig_dst = dd_odo_pkg::TL_QW;
            end
            4'd11: begin
                w.publish = 1'b1;
                w.next    = dd_odo_pkg::NX_END;
            end
            default: begin
                w.next = dd_odo_pkg::NX_END;
            end
        endcase
        return w;
    endfunction

    assign word = prog(step_reg);
    assign busy = busy_reg;

    always_comb begin
        if (busy_reg) begin
            ctrl         = word;
            ctrl.publish = word.publish & out_free;
        end else begin
            ctrl = dd_odo_pkg::CTRL_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (!busy_reg) begin
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
        end else begin
            case (word.next)
                dd_odo_pkg::NX_SEQ: begin
                    step_reg <= step_reg + 1'b1;
                end
                dd_odo_pkg::NX_END: begin
                    if (out_free) begin
                        busy_reg <= 1'b0;
                    end
                end
                default: begin
                    busy_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/dd_odo_dp.sv =====
// ----------------------------------------------------------------------------
// dd_odo_dp: odometry datapath
// pose state, trig lookup, one shared multiplier and the accumulators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dd_odo_dp #(
    parameter int TABLE_BITS = dd_odo_pkg::TABLE_BITS_DEF,
    parameter int POS_WIDTH  = dd_odo_pkg::POS_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [dd_odo_pkg::VEL_W-1:0]  left_vel,
    input  wire logic signed [dd_odo_pkg::VEL_W-1:0]  right_vel,
    input  wire logic        [dd_odo_pkg::GAIN_W-1:0] distance_gain,
    input  wire logic        [dd_odo_pkg::GAIN_W-1:0] turn_gain,
    input  wire logic       [dd_odo_pkg::ANGLE_W-1:0] start_heading,
    input  wire dd_odo_pkg::ctrl_t                    ctrl,
    output logic signed [POS_WIDTH-1:0]               pos_x,
    output logic signed [POS_WIDTH-1:0]               pos_y,
    output logic        [dd_odo_pkg::ANGLE_W-1:0]     heading,
    output logic signed [dd_odo_pkg::QUAT_W-1:0]      quat_z,
    output logic signed [dd_odo_pkg::QUAT_W-1:0]      quat_w
);

    localparam int QW     = TABLE_BITS - 2;
    localparam int SUM_W  = dd_odo_pkg::VEL_W + 1;
    localparam int MA_W   = 34;
    localparam int MB_W   = dd_odo_pkg::GAIN_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int DEL_W  = PROD_W - 15;

    logic signed [POS_WIDTH-1:0]           x_reg;
    logic signed [POS_WIDTH-1:0]           y_reg;
    logic [dd_odo_pkg::ANGLE_W-1:0]        yaw_reg;
    logic                                  started_reg;
    logic signed [SUM_W-1:0]               sum_reg;
    logic signed [SUM_W-1:0]               diff_reg;
    logic signed [15:0]                    cos_reg;
    logic signed [15:0]                    sin_reg;
    logic signed [15:0]                    qz_reg;
    logic signed [15:0]                    qw_reg;
    logic signed [PROD_W-1:0]              prod_reg;
    logic                                  neg_reg;

    logic [dd_odo_pkg::ANGLE_W-1:0]        angle;
    logic [dd_odo_pkg::ANGLE_W:0]          angle_rnd;
    logic [TABLE_BITS-1:0]                 phase;
    logic [QW-1:0]                         phase_j;
    logic [QW:0]                           rom_addr;
    logic [15:0]                           rom_data;
    logic signed [15:0]                    trig_pos;
    logic signed [15:0]                    trig_val;
    logic signed [MA_W-1:0]                mul_a;
    logic signed [MB_W-1:0]                mul_b;
    logic signed [DEL_W-1:0]               delta_raw;
    logic signed [POS_WIDTH-1:0]           delta;
    logic [POS_WIDTH-1:0]                  delta_cin;

    // angle to look up
    always_comb begin
        case (ctrl.ang_sel)
            dd_odo_pkg::ANG_YAW_COS:  angle = yaw_reg + dd_odo_pkg::QUARTER_TURN;
            dd_odo_pkg::ANG_YAW_SIN:  angle = yaw_reg;
            dd_odo_pkg::ANG_HALF_SIN: angle = {1'b0, yaw_reg[31:1]};
            dd_odo_pkg::ANG_HALF_COS: angle = {1'b0, yaw_reg[31:1]} + dd_odo_pkg::QUARTER_TURN;
            default:                  angle = yaw_reg;
        endcase
    end

    // nearest table phase, wrapped, folded onto the quarter wave
    assign angle_rnd = {1'b0, angle} + ((dd_odo_pkg::ANGLE_W + 1)'(1) << (31 - TABLE_BITS));
    assign phase     = angle_rnd[31 -: TABLE_BITS];
    assign phase_j   = phase[QW-1:0];
    assign rom_addr  = phase[QW] ? (((QW + 1)'(1) << QW) - {1'b0, phase_j})
                                 : {1'b0, phase_j};

    dd_odo_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (ctrl.rom_en),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    assign trig_pos = $signed(rom_data);
    assign trig_val = neg_reg ? -trig_pos : trig_pos;

    // shared multiplier operands
    always_comb begin
        case (ctrl.mul_a)
            dd_odo_pkg::MA_SUM:  mul_a = MA_W'(sum_reg);
            dd_odo_pkg::MA_DIFF: mul_a = MA_W'(diff_reg);
            dd_odo_pkg::MA_PROD: mul_a = $signed(prod_reg[MA_W-1:0]);
            default:             mul_a = MA_W'(sum_reg);
        endcase
        case (ctrl.mul_b)
            dd_odo_pkg::MB_COS:   mul_b = MB_W'(cos_reg);
            dd_odo_pkg::MB_SIN:   mul_b = MB_W'(sin_reg);
            dd_odo_pkg::MB_DGAIN: mul_b = $signed({1'b0, distance_gain});
            dd_odo_pkg::MB_TGAIN: mul_b = $signed({1'b0, turn_gain});
            default:              mul_b = MB_W'(cos_reg);
        endcase
    end

    // round half up: floor(p / 2^15) plus bit 14 as carry in
    assign delta_raw = DEL_W'(prod_reg >>> 15);
    assign delta     = POS_WIDTH'(delta_raw);
    assign delta_cin = POS_WIDTH'(prod_reg[14]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            yaw_reg     <= '0;
        end else begin
            if (start) begin
                if (!started_reg) begin
                    x_reg   <= '0;
                    y_reg   <= '0;
                    yaw_reg <= start_heading;
                end
                started_reg <= 1'b1;
            end else begin
                case (ctrl.acc)
                    dd_odo_pkg::ACC_X:   x_reg   <= x_reg + delta + delta_cin;
                    dd_odo_pkg::ACC_Y:   y_reg   <= y_reg + delta + delta_cin;
                    dd_odo_pkg::ACC_YAW: yaw_reg <= yaw_reg + prod_reg[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sum_reg  <= SUM_W'(left_vel) + SUM_W'(right_vel);
            diff_reg <= SUM_W'(right_vel) - SUM_W'(left_vel);
        end
        if (ctrl.rom_en) begin
            neg_reg <= phase[QW+1];
        end
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (ctrl.trig_dst)
            dd_odo_pkg::TL_COS: cos_reg <= trig_val;
            dd_odo_pkg::TL_SIN: sin_reg <= trig_val;
            dd_odo_pkg::TL_QZ:  qz_reg  <= trig_val;
            dd_odo_pkg::TL_QW:  qw_reg  <= trig_val;
            default: ;
        endcase
    end

    assign pos_x   = x_reg;
    assign pos_y   = y_reg;
    assign heading = yaw_reg;
    assign quat_z  = qz_reg;
    assign quat_w  = qw_reg;

`ifndef SYNTHESIS
    // every item leaves the block marked as started
    a_started: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> started_reg)
        else $error("started flag not set after an item");

    // the first item loads the start heading
    a_first_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !started_reg) |=> (yaw_reg == $past(start_heading)))
        else $error("heading not loaded on first item");

    // the first item clears the position
    a_first_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !started_reg) |=> (x_reg == '0 && y_reg == '0))
        else $error("position not cleared on first item");
`endif

endmodule

`default_nettype wire

// ===== design/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry: differential-drive dead-reckoning odometry
// integrates wheel velocities into x, y and heading with a yaw quaternion
// ----------------------------------------------------------------------------
// Each input word is one control tick carrying the left and right wheel
// velocities (signed q8.8). The first word after reset loads the heading
// from start_heading and clears the position. Each word then moves the
// position along the old heading by (left + right) * distance_gain times
// its cosine and sine, rounded half up from q1.15, and turns the heading by
// (right - left) * turn_gain. One result word follows every input word:
// x, y (32 fraction bits, wrapping), the heading as a binary angle
// (2^32 = one turn) and the z, w terms of the yaw quaternion in q1.15.
// Once a word is accepted, s_ready stays low until its microprogram ends, so
// no word is taken while one is in flight: a 12-step microprogram runs four
// sine-table reads and five products through one shared 34x25 multiplier.
// The result sits in an output register, so the next word is taken while a
// result waits; only a result still waiting when the next one is finished
// holds the sequencer on its last step. Configuration writes are taken at
// any time outside reset, cfg_ready is high whenever aresetn is, and should
// only be issued while the block is idle. Neither ready is high in reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_odometry #(
    parameter int TABLE_BITS = dd_odo_pkg::TABLE_BITS_DEF,
    parameter int POS_WIDTH  = dd_odo_pkg::POS_WIDTH_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // input words
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic signed [dd_odo_pkg::VEL_W-1:0]      s_left_vel,
    input  wire logic signed [dd_odo_pkg::VEL_W-1:0]      s_right_vel,
    // result words
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic signed [POS_WIDTH-1:0]                   m_pos_x,
    output logic signed [POS_WIDTH-1:0]                   m_pos_y,
    output logic        [dd_odo_pkg::ANGLE_W-1:0]         m_heading,
    output logic signed [dd_odo_pkg::QUAT_W-1:0]          m_quat_z,
    output logic signed [dd_odo_pkg::QUAT_W-1:0]          m_quat_w,
    // configuration writes
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [dd_odo_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [dd_odo_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // configuration registers
    logic [dd_odo_pkg::GAIN_W-1:0]   distance_gain_reg;
    logic [dd_odo_pkg::GAIN_W-1:0]   turn_gain_reg;
    logic [dd_odo_pkg::ANGLE_W-1:0]  start_heading_reg;

    // sequencer and datapath
    logic                            busy;
    logic                            s_accept;
    logic                            out_free;
    dd_odo_pkg::ctrl_t               ctrl;
    logic signed [POS_WIDTH-1:0]     dp_pos_x;
    logic signed [POS_WIDTH-1:0]     dp_pos_y;
    logic [dd_odo_pkg::ANGLE_W-1:0]  dp_heading;
    logic signed [dd_odo_pkg::QUAT_W-1:0] dp_quat_z;
    logic signed [dd_odo_pkg::QUAT_W-1:0] dp_quat_w;

    // result register
    logic                            m_valid_reg;
    logic signed [POS_WIDTH-1:0]     pos_x_reg;
    logic signed [POS_WIDTH-1:0]     pos_y_reg;
    logic [dd_odo_pkg::ANGLE_W-1:0]  heading_reg;
    logic signed [dd_odo_pkg::QUAT_W-1:0] quat_z_reg;
    logic signed [dd_odo_pkg::QUAT_W-1:0] quat_w_reg;

    // an input word is taken whenever the sequencer is idle and out of reset
    assign s_ready  = !busy && aresetn;
    assign s_accept = s_valid && s_ready;

    // result register can take a new word this cycle
    assign out_free = !m_valid_reg || m_ready;

    assign cfg_ready = aresetn;

    // register writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            distance_gain_reg <= dd_odo_pkg::DISTANCE_GAIN_RST;
            turn_gain_reg     <= dd_odo_pkg::TURN_GAIN_RST;
            start_heading_reg <= dd_odo_pkg::START_HEADING_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dd_odo_pkg::REG_DISTANCE_GAIN:
                    distance_gain_reg <= cfg_data[dd_odo_pkg::GAIN_W-1:0];
                dd_odo_pkg::REG_TURN_GAIN:
                    turn_gain_reg <= cfg_data[dd_odo_pkg::GAIN_W-1:0];
                dd_odo_pkg::REG_START_HEADING:
                    start_heading_reg <= cfg_data[dd_odo_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    dd_odo_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .out_free (out_free),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    dd_odo_dp #(
        .TABLE_BITS (TABLE_BITS),
        .POS_WIDTH  (POS_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s_accept),
        .left_vel      (s_left_vel),
        .right_vel     (s_right_vel),
        .distance_gain (distance_gain_reg),
        .turn_gain     (turn_gain_reg),
        .start_heading (start_heading_reg),
        .ctrl          (ctrl),
        .pos_x         (dp_pos_x),
        .pos_y         (dp_pos_y),
        .heading       (dp_heading),
        .quat_z        (dp_quat_z),
        .quat_w        (dp_quat_w)
    );

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded on the last microprogram step
    always_ff @(posedge aclk) begin
        if (ctrl.publish) begin
            pos_x_reg   <= dp_pos_x;
            pos_y_reg   <= dp_pos_y;
            heading_reg <= dp_heading;
            quat_z_reg  <= dp_quat_z;
            quat_w_reg  <= dp_quat_w;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = pos_x_reg;
    assign m_pos_y   = pos_y_reg;
    assign m_heading = heading_reg;
    assign m_quat_z  = quat_z_reg;
    assign m_quat_w  = quat_w_reg;

`ifndef SYNTHESIS
    // a result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.publish |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // one word at a time through the sequencer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input taken while sequencer busy");

    // a result only appears after the sequencer finished a word
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(ctrl.publish))
        else $error("result valid without a finished word");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_diff_drive_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry: self-checking bench for the odometry block
// drives wheel-velocity words through several gain settings, predicts each
// pose word with a local dead-reckoning model and compares it field by field
// ----------------------------------------------------------------------------

module tb_diff_drive_odometry;
    import dd_odo_pkg::*;

    localparam int TBL_BITS = TABLE_BITS_DEF;
    localparam int POS_W    = POS_WIDTH_DEF;
    localparam int QTR      = 1 << (TBL_BITS - 2);

    // pi/2 with 30 fraction bits, used to build the quarter-wave table
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // receiver holds off for this long after selected result counts
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [VEL_W-1:0] wheel_l;
        logic signed [VEL_W-1:0] wheel_r;
    } vel_pair_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ANGLE_W-1:0]      hd;
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qw;
    } pose_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // block ports, all known from time zero
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic signed [VEL_W-1:0]   s_left_vel  = '0;
    logic signed [VEL_W-1:0]   s_right_vel = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic signed [POS_W-1:0]   m_pos_x;
    logic signed [POS_W-1:0]   m_pos_y;
    logic [ANGLE_W-1:0]        m_heading;
    logic signed [QUAT_W-1:0]  m_quat_z;
    logic signed [QUAT_W-1:0]  m_quat_w;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index   = '0;
    logic [CFG_DATA_W-1:0]     cfg_data    = '0;

    diff_drive_odometry u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_left_vel  (s_left_vel),
        .s_right_vel (s_right_vel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_heading   (m_heading),
        .m_quat_z    (m_quat_z),
        .m_quat_w    (m_quat_w),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // velocity words waiting to be sent, and poses waiting to come back
    vel_pair_t pending_ticks[$];
    pose_t     pose_q[$];

    // no random idling on either side while set
    logic steady = 1'b0;

    int mismatch_cnt = 0;
    int results_seen = 0;
    int hold_left    = 0;

    // ------------------------------------------------------------------------
    // pose predictor: local copy of the registers and the odometry state
    // ------------------------------------------------------------------------
    logic [GAIN_W-1:0]  dist_gain_q  = DISTANCE_GAIN_RST;
    logic [GAIN_W-1:0]  turn_gain_q  = TURN_GAIN_RST;
    logic [ANGLE_W-1:0] start_head_q = START_HEADING_RST;
    logic [POS_W-1:0]   x_pos        = '0;
    logic [POS_W-1:0]   y_pos        = '0;
    logic [ANGLE_W-1:0] yaw          = '0;
    logic               moving       = 1'b0;
    logic [15:0]        sine_lut [0:QTR];

    // quarter-wave sine, q1.15, from a truncated taylor series in q30
    initial begin
        longint unsigned dens [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned ang, ang2, term, sv;
        for (int i = 0; i <= QTR; i++) begin
            ang  = (longint'(i) * HALF_PI_Q30) >> (TBL_BITS - 2);
            ang2 = (ang * ang) >> 30;
            term = ONE_Q30;
            for (int k = 0; k < 6; k++)
                term = ONE_Q30 - ((ang2 * term) >> 30) / dens[k];
            sv = (ang * term) >> 30;
            sv = (sv + 64'd16384) >> 15;
            if (sv > 64'd32767)
                sv = 64'd32767;
            sine_lut[i] = sv[15:0];
        end
    end

    // sine of a binary angle: round to the nearest table phase, which wraps,
    // then fold the quadrant onto the quarter table
    function automatic int bam_sine(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0]  rnd;
        logic [TBL_BITS-1:0] ph;
        logic [1:0]          quad;
        int                  j, v;
        rnd  = a + (32'd1 << (31 - TBL_BITS));
        ph   = rnd[ANGLE_W-1 -: TBL_BITS];
        quad = ph[TBL_BITS-1 -: 2];
        j    = ph[TBL_BITS-3:0];
        v    = quad[0] ? sine_lut[QTR - j] : sine_lut[j];
        return quad[1] ? -v : v;
    endfunction

    // one control tick: move along the old heading, then turn
    function automatic pose_t advance_pose(input logic signed [VEL_W-1:0] l_in,
                                           input logic signed [VEL_W-1:0] r_in);
        int     lv, rv, dg, tg, c, s;
        longint sgain, dturn, dx, dy;
        logic [ANGLE_W-1:0] half;
        pose_t  res;
        lv = l_in;
        rv = r_in;
        dg = dist_gain_q;
        tg = turn_gain_q;
        // first tick after reset: heading from the start register
        if (!moving) begin
            x_pos  = '0;
            y_pos  = '0;
            yaw    = start_head_q;
            moving = 1'b1;
        end
        sgain = longint'(lv + rv) * longint'(dg);
        dturn = longint'(rv - lv) * longint'(tg);
        c     = bam_sine(yaw + QUARTER_TURN);
        s     = bam_sine(yaw);
        // round half up from q1.15, floor on negatives
        dx    = (sgain * longint'(c) + 64'sd16384) >>> 15;
        dy    = (sgain * longint'(s) + 64'sd16384) >>> 15;
        x_pos = x_pos + dx[POS_W-1:0];
        y_pos = y_pos + dy[POS_W-1:0];
        yaw   = yaw + dturn[ANGLE_W-1:0];
        // half yaw by a plain shift keeps quat_z non-negative
        half  = yaw >> 1;
        res.x  = x_pos;
        res.y  = y_pos;
        res.hd = yaw;
        res.qz = QUAT_W'(bam_sine(half));
        res.qw = QUAT_W'(bam_sine(half + QUARTER_TURN));
        return res;
    endfunction

    // register writes and accepted velocity words feed the predictor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DISTANCE_GAIN: dist_gain_q  = cfg_data[GAIN_W-1:0];
                    REG_TURN_GAIN:     turn_gain_q  = cfg_data[GAIN_W-1:0];
                    REG_START_HEADING: start_head_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pose_q.push_back(advance_pose(s_left_vel, s_right_vel));
        end
    end

    // ------------------------------------------------------------------------
    // driver: offers pending words, idles at random unless steady
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        vel_pair_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // current word gone (or none), decide on the next one
            if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
                nxt = pending_ticks.pop_front();
                s_valid     <= 1'b1;
                s_left_vel  <= nxt.wheel_l;
                s_right_vel <= nxt.wheel_r;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks pose words and drives m_ready
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        pose_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    $error("pose word with nothing expected");
                    mismatch_cnt++;
                end else begin
                    want = pose_q.pop_front();
                    check_field("pos_x",   want.x,  m_pos_x);
                    check_field("pos_y",   want.y,  m_pos_y);
                    check_field("heading", want.hd, m_heading);
                    check_field("quat_z",  want.qz, m_quat_z);
                    check_field("quat_w",  want.qw, m_quat_w);
                end
                results_seen++;
                // long back-pressure so the output register fills and the
                // block stops taking velocity words
                if (results_seen == 300 || results_seen == 550)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_tick(input int l, input int r);
        vel_pair_t it;
        it.wheel_l = VEL_W'(l);
        it.wheel_r = VEL_W'(r);
        pending_ticks.push_back(it);
    endtask

    // mostly full-range values, plenty of slow realistic speeds, some extremes
    function automatic logic [VEL_W-1:0] rand_vel();
        case ($urandom_range(0, 9))
            0:       return VEL_W'($urandom_range(0, 3) == 0 ? 16'h8000 :
                                   $urandom_range(0, 2) == 0 ? 16'h7fff :
                                   $urandom_range(0, 1) == 0 ? 16'hffff : 16'h0000);
            1, 2, 3: return VEL_W'(int'($urandom_range(0, 1024)) - 512);
            default: return VEL_W'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int count);
        vel_pair_t it;
        int        d;
        repeat (count) begin
            it.wheel_l = rand_vel();
            if ($urandom_range(0, 3) == 0) begin
                // near-straight driving
                d = int'($urandom_range(0, 64)) - 32;
                it.wheel_r = it.wheel_l + VEL_W'(d);
            end else begin
                it.wheel_r = rand_vel();
            end
            pending_ticks.push_back(it);
        end
    endtask

    // called right after a rising edge; returns on the edge that takes the write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] dgain,
                                input logic [CFG_DATA_W-1:0] tgain,
                                input logic [CFG_DATA_W-1:0] head);
        cfg_write(REG_DISTANCE_GAIN, dgain);
        cfg_write(REG_TURN_GAIN, tgain);
        cfg_write(REG_START_HEADING, head);
        cfg_write(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // sender pause: wait until every word is sent and every pose is back
    task automatic wait_drained();
        do @(negedge aclk); while (pending_ticks.size() != 0 || s_valid || pose_q.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: upper bits of the gain words are dropped, gains at max,
        // start heading just below a full turn so the phase rounds across zero
        program_regs(32'hffff_ffff, 32'hff_ff_ff_ff, 32'hffff_ffff);
        queue_tick(0, 0);
        queue_tick(32767, 32767);
        queue_tick(-32768, -32768);
        queue_tick(32767, -32768);
        queue_tick(-32768, 32767);
        queue_tick(1, 0);
        queue_tick(0, 1);
        queue_tick(-1, -1);
        queue_tick(-1, 1);
        queue_tick(16'h5555, 16'haaaa);
        queue_tick(16'haaaa, 16'h5555);
        queue_tick(256, 256);
        queue_tick(-256, 256);
        queue_tick(100, 90);
        wait_drained();

        // default gains, random idling on both sides
        program_regs(32'(DISTANCE_GAIN_RST), 32'(TURN_GAIN_RST), 32'h0000_0000);
        queue_random(200);
        wait_drained();

        // zero gains: pose frozen
        program_regs(32'h0, 32'h0, 32'h0);
        queue_random(60);
        wait_drained();

        // max distance gain, smallest turn, no idling; position wraps
        @(negedge aclk) steady = 1'b1;
        program_regs(32'h00ff_ffff, 32'h1, 32'h8000_0000);
        queue_random(150);
        wait_drained();
        @(negedge aclk) steady = 1'b0;

        // random gains
        program_regs($urandom, $urandom, $urandom);
        queue_random(120);
        wait_drained();
        program_regs($urandom_range(0, 200000), $urandom_range(0, 2000000), $urandom);
        queue_random(120);
        wait_drained();

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dd_odo_pkg.sv
design/dd_odo_sine_rom.sv
design/dd_odo_seq.sv
design/dd_odo_dp.sv
design/diff_drive_odometry.sv
sim/tb_diff_drive_odometry.sv
